// ===== hdl/assert_macros.svh =====
// Assertion helper macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clk edge outside reset.
`define CHK_IMPL(label, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication checked on every rising clk edge outside reset.
`define CHK_NEXT(label, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

// ===== hdl/rsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rsa_pkg: shared types and constants
// Operation and status codes, controller states and control structs.
// ----------------------------------------------------------------------------
package rsa_pkg;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_PEEK = 3'd2,
    OP_ADD  = 3'd3,
    OP_SUB  = 3'd4,
    OP_MUL  = 3'd5,
    OP_DIV  = 3'd6,
    OP_NONE = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FEW   = 3'd2,
    ST_ZERO  = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_MUL2,
    S_DIV,
    S_WRITE,
    S_OUT
  } state_t;

  localparam int QBITS = 32;
  localparam int FRAC  = 16;
  localparam int DIV_STEPS = 48;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture request
    logic rd;        // read top two entries
    logic exec;      // compute / decide
    logic mul2;      // finish multiply
    logic div_start;
    logic div_step;
    logic write;     // commit stack update
    logic out_pop;   // result taken
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_done;
  } stat_t;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

endpackage

// ===== hdl/rsa_stream_if.sv =====
// ----------------------------------------------------------------------------
// rsa_stream_if: valid/ready channel
// Generic payload channel with source and sink views.
// ----------------------------------------------------------------------------
interface rsa_stream_if #(
  parameter int W = 35
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/rsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsa_ctrl: sequencing controller
// Walks each request through read, execute, optional multiply finish or divide, write and output.
// ----------------------------------------------------------------------------
module rsa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rsa_pkg::stat_t stat,
  output rsa_pkg::cmd_t  cmd
);

  rsa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= rsa_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      rsa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = rsa_pkg::S_READ;
        end
      end
      rsa_pkg::S_READ: begin
        cmd.rd     = 1'b1;
        state_next = rsa_pkg::S_EXEC;
      end
      rsa_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.is_mul) state_next = rsa_pkg::S_MUL2;
        else if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_next    = rsa_pkg::S_DIV;
        end else state_next = rsa_pkg::S_WRITE;
      end
      rsa_pkg::S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = rsa_pkg::S_WRITE;
      end
      rsa_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = rsa_pkg::S_WRITE;
      end
      rsa_pkg::S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = rsa_pkg::S_OUT;
      end
      rsa_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.out_pop = 1'b1;
          state_next  = rsa_pkg::S_IDLE;
        end
      end
      default: state_next = rsa_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hdl/rsa_datapath.sv =====
// ----------------------------------------------------------------------------
// rsa_datapath: stack memory and arithmetic
// Holds the operand stack, fill count, multiplier and restoring divider.
// ----------------------------------------------------------------------------
module rsa_datapath #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rsa_pkg::cmd_t        cmd,
  output rsa_pkg::stat_t       stat,
  input  logic [2:0]           in_mode,
  input  logic signed [31:0]   in_value,
  output logic signed [31:0]   result,
  output logic [2:0]           status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = rsa_pkg::DIV_STEPS;

  logic [31:0]   mem [STACK_DEPTH];
  logic [CW-1:0] fill;
  logic [2:0]    mode;
  logic [31:0]   val;
  logic [31:0]   opa, opb;
  logic [31:0]   res;
  logic [2:0]    st;
  logic          commit;   // 0: no change, 1: update
  logic signed [63:0] prod;
  // divider state
  logic [DW-1:0] dq;       // dividend bits, then quotient
  logic [32:0]   drem;
  logic [31:0]   dden;
  logic          dneg;
  logic [5:0]    dcnt;

  // addresses derived from fill count
  logic [CW-1:0] fm1, fm2;
  assign fm1 = fill - CW'(1);
  assign fm2 = fill - CW'(2);

  logic full, empty, few;
  assign full  = (fill == CW'(STACK_DEPTH));
  assign empty = (fill == '0);
  assign few   = (fill < CW'(2));

  assign stat.is_mul   = (mode == rsa_pkg::OP_MUL) && (st == rsa_pkg::ST_OK) && !few;
  assign stat.is_div   = (mode == rsa_pkg::OP_DIV) && !few && (opb != '0);
  assign stat.div_done = (dcnt == 6'd1);

  // saturating add/sub
  logic signed [32:0] sum;
  always_comb begin
    if (mode == rsa_pkg::OP_SUB)
      sum = {opa[31], opa} - {opb[31], opb};
    else
      sum = {opa[31], opa} + {opb[31], opb};
  end

  function automatic logic [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF)       sat64 = rsa_pkg::SAT_MAX;
    else if (v < -64'sh8000_0000) sat64 = rsa_pkg::SAT_MIN;
    else                          sat64 = v[31:0];
  endfunction

  // divider step
  logic [32:0] dtry;
  assign dtry = {drem[31:0], dq[DW-1]} - {1'b0, dden};

  // quotient with the sign applied, signed
  logic signed [63:0] dquo;
  assign dquo = dneg ? -$signed({16'd0, dq}) : $signed({16'd0, dq});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= in_mode;
      val  <= in_value;
    end
    if (cmd.rd) begin
      opa <= mem[fm1[AW-1:0]];
      opb <= mem[fm2[AW-1:0]];
      res <= '0;
      st  <= rsa_pkg::ST_OK;
      commit <= 1'b0;
    end
    if (cmd.exec) begin
      case (mode)
        rsa_pkg::OP_PUSH: begin
          if (full) st <= rsa_pkg::ST_FULL;
          else begin
            res <= val; commit <= 1'b1;
          end
        end
        rsa_pkg::OP_POP, rsa_pkg::OP_PEEK: begin
          if (empty) st <= rsa_pkg::ST_EMPTY;
          else begin
            res <= opa; commit <= (mode == rsa_pkg::OP_POP);
          end
        end
        rsa_pkg::OP_ADD, rsa_pkg::OP_SUB: begin
          if (few) st <= rsa_pkg::ST_FEW;
          else begin
            commit <= 1'b1;
            if (sum[32] != sum[31]) res <= sum[32] ? rsa_pkg::SAT_MIN : rsa_pkg::SAT_MAX;
            else res <= sum[31:0];
          end
        end
        rsa_pkg::OP_MUL: begin
          if (few) st <= rsa_pkg::ST_FEW;
          else begin
            commit <= 1'b1;
            prod   <= $signed(opa) * $signed(opb);
          end
        end
        rsa_pkg::OP_DIV: begin
          if (few) st <= rsa_pkg::ST_FEW;
          else if (opb == '0) st <= rsa_pkg::ST_ZERO;
          else commit <= 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd.div_start) begin
      dq   <= {(opa[31] ? -opa : opa), 16'd0};
      dden <= opb[31] ? -opb : opb;
      dneg <= opa[31] ^ opb[31];
      drem <= '0;
      dcnt <= 6'(DW);
    end
    if (cmd.div_step) begin
      if (dcnt != '0) begin
        if (!dtry[32]) begin
          drem <= dtry;
          dq   <= {dq[DW-2:0], 1'b1};
        end else begin
          drem <= {drem[31:0], dq[DW-1]};
          dq   <= {dq[DW-2:0], 1'b0};
        end
        dcnt <= dcnt - 6'd1;
      end
    end
    if (cmd.mul2) res <= sat64(prod >>> rsa_pkg::FRAC);
    if (cmd.write && (mode == rsa_pkg::OP_DIV) && commit) res <= sat64(dquo);
  end

  // stack memory writes and fill count
  logic [CW-1:0] waddr;
  logic [31:0]   wdata;
  assign waddr = (mode == rsa_pkg::OP_PUSH) ? fill : fm2;
  assign wdata = (mode == rsa_pkg::OP_DIV) ? sat64(dquo) : res;

  always_ff @(posedge clk) begin
    if (cmd.write && commit && (mode != rsa_pkg::OP_POP))
      mem[waddr[AW-1:0]] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) fill <= '0;
    else if (cmd.write && commit) begin
      if (mode == rsa_pkg::OP_PUSH) fill <= fill + CW'(1);
      else                          fill <= fill - CW'(1);
    end
  end

  assign result = res;
  assign status = st;

endmodule

// ===== hdl/rpn_stack_alu.sv =====
// Sequence: each request passes S_READ, S_EXEC, then S_MUL2 for mul or S_DIV for div
// (48-step restoring divider, one quotient bit per cycle), then S_WRITE and S_OUT.
// One request at a time: the next request is accepted after the result is taken.
// Reset (rst, synchronous): controller goes idle and the stack fill count clears.
// ----------------------------------------------------------------------------
// rpn_stack_alu: reverse-Polish operand stack with Q16.16 arithmetic
// Top level joining controller and datapath.
// ----------------------------------------------------------------------------
module rpn_stack_alu #(
  parameter int STACK_DEPTH = 16
) (
  input logic         clk,
  input logic         rst,
  rsa_stream_if.sink  in_ch,
  rsa_stream_if.source out_ch
);

  rsa_pkg::cmd_t  cmd;
  rsa_pkg::stat_t stat;
  logic signed [31:0] result;
  logic [2:0]         status;

  rsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rsa_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_mode  (in_ch.data[34:32]),
    .in_value (in_ch.data[31:0]),
    .result   (result),
    .status   (status)
  );

  assign out_ch.data = {status, result};

endmodule

// ===== hdl/rsa_checker.sv =====
// ----------------------------------------------------------------------------
// rsa_checker: port-level checks
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [34:0] out_data
);

  // one request in flight: never ready while a result waits
  `CHK_IMPL(a_excl, rst, out_valid, !in_ready)
  // a stalled result holds
  `CHK_NEXT(a_hold, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  // error results carry zero
  `CHK_IMPL(a_zero, rst, out_valid && (out_data[34:32] != rsa_pkg::ST_OK), out_data[31:0] == 32'd0)
  // accepted request is not followed by ready next cycle
  `CHK_NEXT(a_busy, rst, in_valid && in_ready, !in_ready)

endmodule

bind rpn_stack_alu rsa_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
